@@ design/gcd_lcm_pkg.sv @@
// Shared types and constants for the gcd/lcm unit.
`default_nettype none

package gcd_lcm_pkg;

    localparam int unsigned GCD_OUT_W = 32;
    localparam int unsigned LCM_OUT_W = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_step;
        logic mul_load;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic zero_case;
        logic gcd_done;
        logic div_last;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

@@ design/gcd_lcm_dp.sv @@
// Datapath: binary gcd, serial restoring divide, product and output register.
`default_nettype none

module gcd_lcm_dp #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire gcd_lcm_pkg::t_cmd               i_cmd,
    output gcd_lcm_pkg::t_sts                    o_sts,
    input  wire logic [31:0]                     i_first_operand,
    input  wire logic [31:0]                     i_second_operand,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output logic [gcd_lcm_pkg::GCD_OUT_W-1:0]    o_gcd_value,
    output logic [gcd_lcm_pkg::LCM_OUT_W-1:0]    o_lcm_value
);
    import gcd_lcm_pkg::*;

    localparam int unsigned W     = OPERAND_WIDTH;
    localparam int unsigned CNT_W = $clog2(W);

    logic [W-1:0]     r_a, r_b, r_dvd, r_bo, r_g, r_rem;
    logic [CNT_W-1:0] r_k, r_cnt;
    logic             r_zero;
    logic [2*W-1:0]   r_prod;
    logic             r_out_valid;
    logic [GCD_OUT_W-1:0] r_gcd_out;
    logic [LCM_OUT_W-1:0] r_lcm_out;

    logic [W-1:0]   w_in_a, w_in_b;
    logic [W:0]     w_trial;
    logic           w_ge;
    logic [W:0]     w_rem_next;
    logic [2*W-1:0] w_prod;
    logic [W-1:0]   w_diff_ab, w_diff_ba;

    assign w_in_a     = i_first_operand[W-1:0];
    assign w_in_b     = i_second_operand[W-1:0];
    assign w_diff_ab  = r_a - r_b;
    assign w_diff_ba  = r_b - r_a;
    assign w_trial    = {r_rem, r_dvd[W-1]};
    assign w_ge       = w_trial >= {1'b0, r_g};
    assign w_rem_next = w_ge ? (w_trial - {1'b0, r_g}) : w_trial;
    assign w_prod     = r_dvd * r_bo;

    always_comb begin
        o_sts.zero_case = r_zero;
        o_sts.gcd_done  = (r_a == r_b);
        o_sts.div_last  = (r_cnt == '0);
        o_sts.out_busy  = r_out_valid & i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= w_in_a;
            r_b    <= w_in_b;
            r_dvd  <= w_in_a;
            r_bo   <= w_in_b;
            r_k    <= '0;
            r_zero <= (w_in_a == '0) || (w_in_b == '0);
        end else if (i_cmd.gcd_step) begin
            if (r_a == r_b) begin
                // restore the common power of two and prime the divider
                r_g   <= r_a << r_k;
                r_rem <= '0;
                r_cnt <= CNT_W'(W - 1);
            end else if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a > r_b) begin
                r_a <= w_diff_ab >> 1;
            end else begin
                r_b <= w_diff_ba >> 1;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= w_rem_next[W-1:0];
            r_dvd <= {r_dvd[W-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.mul_load) begin
            r_prod <= w_prod;
        end
    end

    // Output register; frees as soon as the result transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_zero) begin
                r_gcd_out <= GCD_OUT_W'(r_a | r_b);
                r_lcm_out <= '0;
            end else begin
                r_gcd_out <= GCD_OUT_W'(r_g);
                r_lcm_out <= LCM_OUT_W'(r_prod);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gcd_value = r_gcd_out;
    assign o_lcm_value = r_lcm_out;

endmodule

`default_nettype wire

@@ design/gcd_lcm_ctrl.sv @@
// Controller: sequences gcd, divide, multiply and result hand-off.
`default_nettype none

module gcd_lcm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire gcd_lcm_pkg::t_sts i_sts,
    output gcd_lcm_pkg::t_cmd      o_cmd
);
    import gcd_lcm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_GCD;
                end
            end
            ST_GCD: begin
                if (i_sts.zero_case) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                    if (i_sts.gcd_done) begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/gcd_lcm_unit.sv @@
// Top level of the gcd/lcm unit: controller plus datapath.
//
//   channel  | valid          | stall          | payload
//   ---------+----------------+----------------+-----------------------------------
//   input    | i_in_valid     | o_in_stall     | i_first_operand, i_second_operand
//   result   | o_out_valid    | i_out_stall    | o_gcd_value, o_lcm_value
//
// One pair at a time: accept, up to 2*OPERAND_WIDTH-1 binary gcd steps, OPERAND_WIDTH
// restoring divide steps for first/gcd, one multiply, one output load. A zero operand
// skips to the result.
// Synchronous active-low reset clears the controller and the result valid.
// A stalled result sits in the output register while the next pair is taken in;
// a finished pair then waits until that result has been transferred.
`default_nettype none

module gcd_lcm_unit #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [31:0]                     i_first_operand,
    input  wire logic [31:0]                     i_second_operand,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [gcd_lcm_pkg::GCD_OUT_W-1:0]    o_gcd_value,
    output logic [gcd_lcm_pkg::LCM_OUT_W-1:0]    o_lcm_value
);
    import gcd_lcm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    gcd_lcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gcd_lcm_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_gcd_value      (o_gcd_value),
        .o_lcm_value      (o_lcm_value)
    );

endmodule

`default_nettype wire
